[sv/swsb_pkg.sv]
// shared types, constants and helpers for the sliding window send buffer
package swsb_pkg;

  localparam int MAX_WINDOW    = 32;
  localparam int MAX_PDU_BYTES = 256;
  localparam int PDU_WORDS     = (MAX_PDU_BYTES + 7) / 8;
  localparam int SLOT_W        = $clog2(MAX_WINDOW);
  localparam int WORD_IDX_W    = $clog2(PDU_WORDS);
  localparam int WS_W          = 6;
  localparam int STAGE_CNT_W   = 10;

  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_GET = 2'd1,
    FN_LOW = 2'd2,
    FN_ACK = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WLO,
    ST_WHI,
    ST_COPY,
    ST_COMMIT,
    ST_GCHK,
    ST_META,
    ST_MCHK,
    ST_RD,
    ST_RPLY,
    ST_CLR,
    ST_ACKF,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [WORD_IDX_W-1:0] waddr;
    logic [63:0]           wdata;
    logic [7:0]            wbe;
    logic [WORD_IDX_W-1:0] raddr;
  } stage_req_t;

  function automatic logic [WS_W-1:0] eff_size(input logic [WS_W-1:0] ws);
    logic [WS_W-1:0] r;
    r = ws;
    if (ws == '0) r = WS_W'(1);
    else if (ws > WS_W'(MAX_WINDOW)) r = WS_W'(MAX_WINDOW);
    return r;
  endfunction

  function automatic logic [31:0] edge_above(input logic [31:0] base,
                                             input logic [WS_W-1:0] ws);
    logic [32:0] s;
    s = {1'b0, base} + 33'(ws);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[sv/swsb_stage_mem.sv]
// staging buffer for the pdu being assembled, byte-enable write, registered read
module swsb_stage_mem (
  input  logic                clk,
  input  swsb_pkg::stage_req_t req,
  output logic [63:0]         rdata
);
  import swsb_pkg::*;

  logic [63:0] mem [PDU_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      for (int i = 0; i < 8; i++) begin
        if (req.wbe[i]) mem[req.waddr][i*8 +: 8] <= req.wdata[i*8 +: 8];
      end
    end
    rdata <= mem[req.raddr];
  end

endmodule

[sv/sliding_window_send_buffer.sv]
// sliding window send buffer, steps from accept to the next accept:
// add word: staged in low and high halves; the last word copies and records the pdu
// get: range and metadata checks, then a payload read and a reply per replayed word
// ack: frees acked slots, one valid bit cleared per cycle, then moves the lower edge
// rst (synchronous) restores window 16, empty window and no staged bytes;
// one item in work at a time, result held in an output register
module sliding_window_send_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  func,
  input  logic [31:0] seq_num,
  input  logic [63:0] data_word,
  input  logic [3:0]  data_bytes,
  input  logic        data_last,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        status,
  output logic [31:0] seq_out,
  output logic [8:0]  pdu_length,
  output logic [63:0] out_word,
  output logic        window_open,
  output logic [31:0] next_seq,
  output logic [31:0] lowest_seq,
  output logic        last
);
  import swsb_pkg::*;

  state_t state, state_next;

  logic [WS_W-1:0]        window_size;
  logic [31:0]            lower;
  logic [31:0]            nxt;
  logic [31:0]            upper;
  logic [SLOT_W-1:0]      lower_idx;
  logic [SLOT_W-1:0]      next_idx;
  logic [MAX_WINDOW-1:0]  valid;
  logic [STAGE_CNT_W-1:0] staged;

  logic [31:0]            op_seq;
  logic [63:0]            op_word;
  logic [3:0]             op_nb;
  logic                   op_last;
  logic [STAGE_CNT_W-1:0] off;
  logic [STAGE_CNT_W-1:0] len_q;
  logic [WS_W-1:0]        cnt;
  logic [WS_W-1:0]        nw;
  logic [SLOT_W-1:0]      idx_q;
  logic                   res_status;
  logic [31:0]            res_seq;
  logic [8:0]             res_len;

  logic                   copy_pend;
  logic [WORD_IDX_W-1:0]  copy_k;

  logic [WS_W-1:0]        ws;
  logic                   accept;
  logic                   out_free;

  // memories
  logic [63:0]            payload [MAX_WINDOW*PDU_WORDS];
  logic [63:0]            pay_q;
  logic [40:0]            meta [MAX_WINDOW];
  logic [40:0]            meta_q;
  logic [63:0]            stage_q;
  stage_req_t             sreq;

  logic [3:0]             nb;
  logic [STAGE_CNT_W-1:0] stage_sum;
  logic [STAGE_CNT_W-1:0] stage_sat;
  logic [7:0]             bmask;
  logic [127:0]           shifted;
  logic [15:0]            be16;
  logic [31:0]            rr_c;
  logic [31:0]            diff;
  logic [WS_W-1:0]        idx_sum;
  logic [SLOT_W-1:0]      idx_calc;
  logic [STAGE_CNT_W-1:0] len_round;
  logic [63:0]            rmask;
  logic                   fin;

  assign ws        = eff_size(window_size);
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] x,
                                                 input logic [WS_W-1:0] w);
    return ({1'b0, x} == w - WS_W'(1)) ? '0 : x + SLOT_W'(1);
  endfunction

  // add word byte placement
  always_comb begin
    nb        = (data_bytes > 4'd8) ? 4'd8 : data_bytes;
    stage_sum = staged + STAGE_CNT_W'(nb);
    stage_sat = (stage_sum > STAGE_CNT_W'(MAX_PDU_BYTES + 1)) ?
                STAGE_CNT_W'(MAX_PDU_BYTES + 1) : stage_sum;
    for (int i = 0; i < 8; i++) begin
      bmask[i] = (4'(i) < op_nb) &&
                 ((off + STAGE_CNT_W'(i)) < STAGE_CNT_W'(MAX_PDU_BYTES));
    end
    shifted = {64'b0, op_word} << {off[2:0], 3'b000};
    be16    = {8'b0, bmask} << off[2:0];
  end

  always_comb begin
    sreq.we    = (state == ST_WLO) || (state == ST_WHI);
    sreq.waddr = (state == ST_WHI) ? off[7:3] + WORD_IDX_W'(1) : off[7:3];
    sreq.wdata = (state == ST_WHI) ? shifted[127:64] : shifted[63:0];
    sreq.wbe   = (state == ST_WHI) ? be16[15:8] : be16[7:0];
    sreq.raddr = cnt[WORD_IDX_W-1:0];
  end

  swsb_stage_mem u_stage (
    .clk   (clk),
    .req   (sreq),
    .rdata (stage_q)
  );

  always_comb begin
    rr_c      = (seq_num > nxt) ? nxt : seq_num;
    diff      = op_seq - lower;
    idx_sum   = {1'b0, lower_idx} + diff[WS_W-1:0];
    idx_calc  = (idx_sum >= ws) ? SLOT_W'(idx_sum - ws) : idx_sum[SLOT_W-1:0];
    len_round = STAGE_CNT_W'(meta_q[8:0]) + STAGE_CNT_W'(7);
    fin       = (cnt == nw - WS_W'(1));
    rmask     = '1;
    if (fin && len_q[2:0] != 3'd0) rmask = ~(64'hFFFF_FFFF_FFFF_FFFF << {len_q[2:0], 3'b000});
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (copy_pend) payload[{next_idx, copy_k}] <= stage_q;
    pay_q <= payload[{idx_q, cnt[WORD_IDX_W-1:0]}];
    if (state == ST_COMMIT) meta[next_idx] <= {nxt, len_q[8:0]};
    meta_q <= meta[idx_q];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(func))
            FN_ADD: state_next = ST_WLO;
            FN_GET: state_next = ST_GCHK;
            FN_LOW: state_next = (lower == nxt) ? ST_EMIT : ST_GCHK;
            FN_ACK: begin
              if (seq_num <= lower) state_next = ST_EMIT;
              else if (rr_c == lower) state_next = ST_ACKF;
              else state_next = ST_CLR;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_WLO: state_next = ST_WHI;
      ST_WHI: begin
        if (!op_last) state_next = ST_IDLE;
        else if (nxt >= upper || len_q == '0 ||
                 len_q > STAGE_CNT_W'(MAX_PDU_BYTES)) state_next = ST_EMIT;
        else state_next = ST_COPY;
      end
      ST_COPY:   state_next = fin ? ST_COMMIT : ST_COPY;
      ST_COMMIT: state_next = ST_EMIT;
      ST_GCHK:   state_next = (op_seq < lower || op_seq >= nxt) ? ST_EMIT : ST_META;
      ST_META:   state_next = ST_MCHK;
      ST_MCHK:   state_next = (!valid[idx_q] || meta_q[40:9] != op_seq) ? ST_EMIT : ST_RD;
      ST_RD:     state_next = ST_RPLY;
      ST_RPLY:   if (out_free) state_next = fin ? ST_IDLE : ST_RD;
      ST_CLR:    state_next = fin ? ST_ACKF : ST_CLR;
      ST_ACKF:   state_next = ST_EMIT;
      ST_EMIT:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // window state and work registers
  always_ff @(posedge clk) begin
    copy_pend <= (state == ST_COPY);
    copy_k    <= cnt[WORD_IDX_W-1:0];
    if (rst) begin
      window_size <= WS_W'(16);
      lower       <= '0;
      nxt         <= '0;
      upper       <= 32'd16;
      lower_idx   <= '0;
      next_idx    <= '0;
      valid       <= '0;
      staged      <= '0;
    end else if (cfg_we) begin
      window_size <= cfg_data;
      lower       <= '0;
      nxt         <= '0;
      upper       <= 32'(eff_size(cfg_data));
      lower_idx   <= '0;
      next_idx    <= '0;
      valid       <= '0;
      staged      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_word <= data_word;
            op_nb   <= nb;
            op_last <= data_last;
            off     <= staged;
            cnt     <= '0;
            case (func_t'(func))
              FN_ADD: begin
                len_q  <= stage_sat;
                staged <= data_last ? '0 : stage_sat;
              end
              FN_GET: op_seq <= seq_num;
              FN_LOW: begin
                op_seq     <= lower;
                res_status <= 1'b1;
                res_seq    <= lower;
                res_len    <= '0;
              end
              FN_ACK: begin
                op_seq     <= rr_c;
                nw         <= WS_W'(rr_c - lower);
                res_status <= 1'b1;
                res_seq    <= lower;
                res_len    <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_WHI: begin
          res_status <= 1'b1;
          res_seq    <= nxt;
          res_len    <= '0;
          nw         <= WS_W'((len_q + STAGE_CNT_W'(7)) >> 3);
        end
        ST_COPY: if (!fin) cnt <= cnt + WS_W'(1);
        ST_COMMIT: begin
          valid[next_idx] <= 1'b1;
          res_status      <= 1'b0;
          res_seq         <= nxt;
          res_len         <= len_q[8:0];
          nxt             <= nxt + 32'd1;
          next_idx        <= slot_inc(next_idx, ws);
        end
        ST_GCHK: begin
          idx_q      <= idx_calc;
          res_status <= 1'b1;
          res_seq    <= op_seq;
          res_len    <= '0;
        end
        ST_MCHK: begin
          len_q <= STAGE_CNT_W'(meta_q[8:0]);
          nw    <= WS_W'(len_round >> 3);
        end
        ST_RPLY: if (out_free && !fin) cnt <= cnt + WS_W'(1);
        ST_CLR: begin
          valid[lower_idx] <= 1'b0;
          lower_idx        <= slot_inc(lower_idx, ws);
          if (!fin) cnt <= cnt + WS_W'(1);
        end
        ST_ACKF: begin
          lower      <= op_seq;
          upper      <= edge_above(op_seq, ws);
          res_status <= 1'b0;
          res_seq    <= op_seq;
          res_len    <= '0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free && (state == ST_EMIT || state == ST_RPLY)) begin
      rsp_valid   <= 1'b1;
      window_open <= (nxt < upper);
      next_seq    <= nxt;
      lowest_seq  <= lower;
      if (state == ST_RPLY) begin
        status     <= 1'b0;
        seq_out    <= op_seq;
        pdu_length <= len_q[8:0];
        out_word   <= pay_q & rmask;
        last       <= fin;
      end else begin
        status     <= res_status;
        seq_out    <= res_seq;
        pdu_length <= res_len;
        out_word   <= '0;
        last       <= 1'b1;
      end
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

[sv/swsb_checker.sv]
// port-level checks for the sliding window send buffer, bound to the top level
module swsb_props (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic        status,
  input logic [31:0] seq_out,
  input logic [8:0]  pdu_length,
  input logic [63:0] out_word,
  input logic [31:0] next_seq,
  input logic [31:0] lowest_seq
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(seq_out) && $stable(out_word))
    else $error("stalled transaction changed");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> pdu_length == 9'd0 && out_word == 64'd0)
    else $error("error transaction carries data");

  a_word_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_word != 64'd0 |-> pdu_length != 9'd0)
    else $error("payload word without length");

  a_edges: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> lowest_seq <= next_seq)
    else $error("lower edge above next sequence");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("transaction right after reset");

endmodule

bind sliding_window_send_buffer swsb_props u_swsb_props (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp_valid),
  .rsp_stall  (rsp_stall),
  .status     (status),
  .seq_out    (seq_out),
  .pdu_length (pdu_length),
  .out_word   (out_word),
  .next_seq   (next_seq),
  .lowest_seq (lowest_seq)
);
